// ----- sv/mips_subset_execute_core_macros.svh -----
// Assertion macros shared by the execute core RTL.
// No dependencies; taken in by `include where assertions are written.
`ifndef MIPS_SUBSET_EXECUTE_CORE_MACROS_SVH
`define MIPS_SUBSET_EXECUTE_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define MSE_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define MSE_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/mse_pkg.sv -----
// Opcode and function codes, result and write-port types for the execute core.
// No dependencies.
package mse_pkg;

  localparam int unsigned XLEN = 32;
  localparam int unsigned REG_AW = 5;

  localparam logic [5:0] OP_RTYPE = 6'h00;
  localparam logic [5:0] OP_BEQ   = 6'h04;
  localparam logic [5:0] OP_BNE   = 6'h05;
  localparam logic [5:0] OP_ADDI  = 6'h08;
  localparam logic [5:0] OP_ADDIU = 6'h09;
  localparam logic [5:0] OP_ANDI  = 6'h0C;
  localparam logic [5:0] OP_ORI   = 6'h0D;
  localparam logic [5:0] OP_XORI  = 6'h0E;
  localparam logic [5:0] OP_LUI   = 6'h0F;
  localparam logic [5:0] OP_LW    = 6'h23;
  localparam logic [5:0] OP_SW    = 6'h2B;

  localparam logic [5:0] FN_SLL  = 6'h00;
  localparam logic [5:0] FN_SRL  = 6'h02;
  localparam logic [5:0] FN_SRA  = 6'h03;
  localparam logic [5:0] FN_ADD  = 6'h20;
  localparam logic [5:0] FN_ADDU = 6'h21;
  localparam logic [5:0] FN_SUB  = 6'h22;
  localparam logic [5:0] FN_SUBU = 6'h23;
  localparam logic [5:0] FN_AND  = 6'h24;
  localparam logic [5:0] FN_OR   = 6'h25;
  localparam logic [5:0] FN_XOR  = 6'h26;
  localparam logic [5:0] FN_NOR  = 6'h27;
  localparam logic [5:0] FN_SLT  = 6'h2A;
  localparam logic [5:0] FN_SLTU = 6'h2B;

  localparam logic [XLEN-1:0] PC_STEP = 32'd4;

  typedef struct packed {
    logic              status;
    logic [XLEN-1:0]   next_pc;
    logic              write_enable;
    logic [REG_AW-1:0] write_index;
    logic [XLEN-1:0]   write_value;
  } result_t;

  typedef struct packed {
    logic              en;
    logic [REG_AW-1:0] idx;
    logic [XLEN-1:0]   val;
  } wr_t;

endpackage

// ----- sv/mse_regfile.sv -----
// Register file: 32 x 32 storage, per-entry valid bits cleared at reset,
// registered two-port read with bypass of the write in flight. Uses mse_pkg.
module mse_regfile (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          rd_en_i,
  input  logic [mse_pkg::REG_AW-1:0]    rs_i,
  input  logic [mse_pkg::REG_AW-1:0]    rt_i,
  input  mse_pkg::wr_t                  wr_i,
  output logic [mse_pkg::XLEN-1:0]      a_o,
  output logic [mse_pkg::XLEN-1:0]      b_o
);

  localparam int unsigned Depth = 2 ** mse_pkg::REG_AW;

  logic [mse_pkg::XLEN-1:0] mem [Depth];
  logic [Depth-1:0]         valid_q;

  logic [mse_pkg::XLEN-1:0] rdata_a_q, rdata_b_q, fwd_val_q;
  logic                     va_q, vb_q, fwa_q, fwb_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.idx] <= wr_i.val;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rdata_a_q <= mem[rs_i];
      rdata_b_q <= mem[rt_i];
      fwd_val_q <= wr_i.val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      va_q    <= 1'b0;
      vb_q    <= 1'b0;
      fwa_q   <= 1'b0;
      fwb_q   <= 1'b0;
    end else begin
      if (wr_i.en) begin
        valid_q[wr_i.idx] <= 1'b1;
      end
      if (rd_en_i) begin
        va_q  <= valid_q[rs_i];
        vb_q  <= valid_q[rt_i];
        fwa_q <= wr_i.en && (wr_i.idx == rs_i);
        fwb_q <= wr_i.en && (wr_i.idx == rt_i);
      end
    end
  end

  assign a_o = fwa_q ? fwd_val_q : (va_q ? rdata_a_q : '0);
  assign b_o = fwb_q ? fwd_val_q : (vb_q ? rdata_b_q : '0);

endmodule

// ----- sv/mse_alu.sv -----
// Decode and execute of one instruction word against its operands and the pc.
// Purely combinational. Uses mse_pkg.
module mse_alu (
  input  logic [31:0]                instr_i,
  input  logic [mse_pkg::XLEN-1:0]   a_i,
  input  logic [mse_pkg::XLEN-1:0]   b_i,
  input  logic [mse_pkg::XLEN-1:0]   pc_i,
  output mse_pkg::result_t           res_o
);

  logic [5:0]                 op, fn;
  logic [4:0]                 rt, rd, sh;
  logic [15:0]                imm;
  logic [mse_pkg::XLEN-1:0]   val, imm_sx, imm_zx;
  logic [mse_pkg::REG_AW-1:0] dst;
  logic                       writes, ok;

  assign op     = instr_i[31:26];
  assign rt     = instr_i[20:16];
  assign rd     = instr_i[15:11];
  assign sh     = instr_i[10:6];
  assign fn     = instr_i[5:0];
  assign imm    = instr_i[15:0];
  assign imm_sx = {{16{imm[15]}}, imm};
  assign imm_zx = {16'h0000, imm};

  always_comb begin
    val    = '0;
    writes = 1'b1;
    ok     = 1'b1;
    dst    = rt;
    if (op == mse_pkg::OP_RTYPE) begin
      dst = rd;
      case (fn)
        mse_pkg::FN_ADD, mse_pkg::FN_ADDU: val = a_i + b_i;
        mse_pkg::FN_SUB, mse_pkg::FN_SUBU: val = a_i - b_i;
        mse_pkg::FN_AND:  val = a_i & b_i;
        mse_pkg::FN_OR:   val = a_i | b_i;
        mse_pkg::FN_XOR:  val = a_i ^ b_i;
        mse_pkg::FN_NOR:  val = ~(a_i | b_i);
        mse_pkg::FN_SLT:  val = {31'd0, $signed(a_i) < $signed(b_i)};
        mse_pkg::FN_SLTU: val = {31'd0, a_i < b_i};
        mse_pkg::FN_SLL:  val = b_i << sh;
        mse_pkg::FN_SRL:  val = b_i >> sh;
        mse_pkg::FN_SRA:  val = $unsigned($signed(b_i) >>> sh);
        default:          ok  = 1'b0;
      endcase
    end else begin
      case (op)
        mse_pkg::OP_ADDI, mse_pkg::OP_ADDIU: val = a_i + imm_sx;
        mse_pkg::OP_ANDI: val = a_i & imm_zx;
        mse_pkg::OP_ORI:  val = a_i | imm_zx;
        mse_pkg::OP_XORI: val = a_i ^ imm_zx;
        mse_pkg::OP_LUI:  val = {imm, 16'h0000};
        mse_pkg::OP_LW, mse_pkg::OP_SW, mse_pkg::OP_BEQ, mse_pkg::OP_BNE: writes = 1'b0;
        default:          ok  = 1'b0;
      endcase
    end
  end

  always_comb begin
    res_o.status       = !ok;
    res_o.next_pc      = ok ? pc_i + mse_pkg::PC_STEP : pc_i;
    res_o.write_enable = ok && writes && (dst != '0);
    res_o.write_index  = res_o.write_enable ? dst : '0;
    res_o.write_value  = res_o.write_enable ? val : '0;
  end

endmodule

// ----- sv/mips_subset_execute_core.sv -----
// Top level of the execute core: operand stage, execute, result register.
// Depends on mse_pkg, mse_regfile, mse_alu and the assertion macro header.
//
// Usage:
//   Slave channel s_axis_* carries one 32-bit instruction word per transfer.
//   Master channel m_axis_* returns one result per instruction: tuser is the
//   error status, tdata the next pc, the write flag, index and value.
//   From the input transfer to the result becoming valid, the register file
//   is first read into the operand stage, then the instruction executes and
//   loads the result register while updating the register file and pc.
//   One instruction is taken every cycle while m_axis_tready is high; the
//   register file write is bypassed into the operand read of the next word.
//   Reset clears the pc and marks every register entry as zero at once,
//   so the first transfer may follow reset immediately.
//   When the receiver holds m_axis_tready low the result register holds,
//   the operand stage holds behind it and s_axis_tready drops once both are
//   full; no state is updated while an instruction waits.
`include "mips_subset_execute_core_macros.svh"

module mips_subset_execute_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] instruction
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // [31:0] next_pc, [32] write_enable,
                                      // [37:33] write_index, [69:38] write_value
  output logic        m_axis_tuser    // [0] status
);

  logic                     s1_valid_q;
  logic [31:0]              instr_q;
  logic [mse_pkg::XLEN-1:0] pc_q;
  logic                     out_valid_q;
  mse_pkg::result_t         out_q;

  logic                     s1_adv, in_fire, exec_fire;
  logic [mse_pkg::XLEN-1:0] op_a, op_b;
  mse_pkg::result_t         res;
  mse_pkg::wr_t             wr;

  assign s1_adv        = !out_valid_q || m_axis_tready;
  assign exec_fire     = s1_valid_q && s1_adv;
  assign s_axis_tready = !s1_valid_q || s1_adv;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  assign wr.en  = exec_fire && res.write_enable;
  assign wr.idx = res.write_index;
  assign wr.val = res.write_value;

  mse_regfile u_regfile (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rd_en_i (in_fire),
    .rs_i    (s_axis_tdata[25:21]),
    .rt_i    (s_axis_tdata[20:16]),
    .wr_i    (wr),
    .a_o     (op_a),
    .b_o     (op_b)
  );

  mse_alu u_alu (
    .instr_i (instr_q),
    .a_i     (op_a),
    .b_i     (op_b),
    .pc_i    (pc_q),
    .res_o   (res)
  );

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      instr_q <= s_axis_tdata;
    end
    if (exec_fire) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      pc_q        <= '0;
    end else begin
      if (s_axis_tready) begin
        s1_valid_q <= s_axis_tvalid;
      end
      if (s1_adv) begin
        out_valid_q <= s1_valid_q;
      end
      if (exec_fire) begin
        pc_q <= res.next_pc;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.status;
  assign m_axis_tdata  = {2'b00, out_q.write_value, out_q.write_index,
                          out_q.write_enable, out_q.next_pc};

  `MSE_ASSERT_NOW(a_err_no_write, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser, m_axis_tdata[32] == 1'b0, "error result carries a register write")
  `MSE_ASSERT_NOW(a_no_r0_write, clk_i, rst_ni, m_axis_tvalid && m_axis_tdata[32], m_axis_tdata[37:33] != 5'd0, "write to register zero reported")
  `MSE_ASSERT_NEXT(a_pc_step, clk_i, rst_ni, exec_fire && !res.status, pc_q == $past(pc_q) + mse_pkg::PC_STEP, "pc did not advance by four")
  `MSE_ASSERT_NEXT(a_pc_hold, clk_i, rst_ni, exec_fire && res.status, pc_q == $past(pc_q), "pc changed on unknown instruction")
  `MSE_ASSERT_NEXT(a_result_loaded, clk_i, rst_ni, exec_fire, m_axis_tvalid && (m_axis_tdata[31:0] == pc_q), "result register not loaded with the new pc")

endmodule

// ----- sim/testbench.sv -----
// Self-checking testbench for mips_subset_execute_core: directed and random instruction
// words on the slave stream, results checked against an in-bench execute model.
// Depends on mse_pkg and the execute core RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RANDOM_ITEMS = 1900;
  localparam int unsigned CALM_FROM    = 1600;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned HOLD_AT      = 1000;

  localparam logic [5:0] OP_UNDEFINED = 6'h3F;
  localparam logic [5:0] FN_UNDEFINED = 6'h01;

  localparam logic [5:0] R_FUNCTS [13] = '{mse_pkg::FN_SLL, mse_pkg::FN_SRL, mse_pkg::FN_SRA,
                                           mse_pkg::FN_ADD, mse_pkg::FN_ADDU, mse_pkg::FN_SUB,
                                           mse_pkg::FN_SUBU, mse_pkg::FN_AND, mse_pkg::FN_OR,
                                           mse_pkg::FN_XOR, mse_pkg::FN_NOR, mse_pkg::FN_SLT,
                                           mse_pkg::FN_SLTU};
  localparam logic [5:0] I_OPS [6] = '{mse_pkg::OP_ADDI, mse_pkg::OP_ADDIU, mse_pkg::OP_ANDI,
                                       mse_pkg::OP_ORI, mse_pkg::OP_XORI, mse_pkg::OP_LUI};
  localparam logic [5:0] PASS_OPS [4] = '{mse_pkg::OP_LW, mse_pkg::OP_SW, mse_pkg::OP_BEQ,
                                          mse_pkg::OP_BNE};

  class mips_exec_model;
    logic [31:0]      regs [32];
    logic [31:0]      pc;
    mse_pkg::result_t pending_results [$];
    int unsigned      errors;
    int unsigned      checked;
    int unsigned      writes;
    int unsigned      rejected;

    function new();
      foreach (regs[i]) regs[i] = '0;
      pc       = '0;
      errors   = 0;
      checked  = 0;
      writes   = 0;
      rejected = 0;
    endfunction

    function void note_instruction(logic [31:0] word);
      logic [5:0]       op;
      logic [5:0]       fn;
      logic [4:0]       rs;
      logic [4:0]       rt;
      logic [4:0]       rd;
      logic [4:0]       sh;
      logic [15:0]      imm;
      logic [31:0]      a;
      logic [31:0]      b;
      logic [31:0]      val;
      logic [4:0]       dst;
      bit               writes_reg;
      bit               known;
      mse_pkg::result_t exp;
      op  = word[31:26];
      rs  = word[25:21];
      rt  = word[20:16];
      rd  = word[15:11];
      sh  = word[10:6];
      fn  = word[5:0];
      imm = word[15:0];
      a   = regs[rs];
      b   = regs[rt];
      val = '0;
      writes_reg = 1'b1;
      known      = 1'b1;
      if (op == mse_pkg::OP_RTYPE) begin
        dst = rd;
        case (fn)
          mse_pkg::FN_ADD, mse_pkg::FN_ADDU: val = a + b;
          mse_pkg::FN_SUB, mse_pkg::FN_SUBU: val = a - b;
          mse_pkg::FN_AND:  val = a & b;
          mse_pkg::FN_OR:   val = a | b;
          mse_pkg::FN_XOR:  val = a ^ b;
          mse_pkg::FN_NOR:  val = ~(a | b);
          mse_pkg::FN_SLT:  val = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
          mse_pkg::FN_SLTU: val = (a < b) ? 32'd1 : 32'd0;
          mse_pkg::FN_SLL:  val = b << sh;
          mse_pkg::FN_SRL:  val = b >> sh;
          mse_pkg::FN_SRA:  val = $unsigned($signed(b) >>> sh);
          default:          known = 1'b0;
        endcase
      end else begin
        dst = rt;
        case (op)
          mse_pkg::OP_ADDI, mse_pkg::OP_ADDIU: val = a + {{16{imm[15]}}, imm};
          mse_pkg::OP_ANDI: val = a & {16'h0000, imm};
          mse_pkg::OP_ORI:  val = a | {16'h0000, imm};
          mse_pkg::OP_XORI: val = a ^ {16'h0000, imm};
          mse_pkg::OP_LUI:  val = {imm, 16'h0000};
          mse_pkg::OP_LW, mse_pkg::OP_SW, mse_pkg::OP_BEQ, mse_pkg::OP_BNE:
            writes_reg = 1'b0;
          default:          known = 1'b0;
        endcase
      end
      exp = '0;
      if (!known) begin
        exp.status  = 1'b1;
        exp.next_pc = pc;
        rejected++;
      end else begin
        pc = pc + mse_pkg::PC_STEP;
        if (writes_reg && dst != 5'd0) begin
          regs[dst]         = val;
          exp.write_enable  = 1'b1;
          exp.write_index   = dst;
          exp.write_value   = val;
          writes++;
        end
        exp.next_pc = pc;
      end
      pending_results = {pending_results, exp};
    endfunction

    function void compare_field(string name, logic [31:0] exp, logic [31:0] act);
      if (exp !== act) begin
        $display("%0t: %s mismatch: expected %h actual %h", $time, name, exp, act);
        errors++;
      end
    endfunction

    function void check_result(logic status, logic [71:0] data);
      mse_pkg::result_t exp;
      checked++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result: expected none actual tuser %b tdata %h",
                 $time, status, data);
        errors++;
        return;
      end
      exp = pending_results.pop_front();
      compare_field("status", 32'(exp.status), 32'(status));
      compare_field("next_pc", exp.next_pc, data[31:0]);
      compare_field("write_enable", 32'(exp.write_enable), 32'(data[32]));
      compare_field("write_index", 32'(exp.write_index), 32'(data[37:33]));
      compare_field("write_value", exp.write_value, data[69:38]);
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [71:0] m_axis_tdata;
  logic        m_axis_tuser;

  mips_exec_model model;
  int unsigned    cycles;
  int unsigned    sent;
  bit             calm;

  mips_subset_execute_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("mips_subset_execute_core test failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) model.note_instruction(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) model.check_result(m_axis_tuser, m_axis_tdata);
    end
  end

  // receiver: random stalls, one long hold, none in the calm tail
  initial begin
    bit held;
    held = 1'b0;
    m_axis_tready = 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (!held && cycles >= HOLD_AT) begin
        held = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end
    end
  end

  function automatic logic [31:0] enc_r(logic [5:0] fn, logic [4:0] rs, logic [4:0] rt,
                                        logic [4:0] rd, logic [4:0] sh);
    return {mse_pkg::OP_RTYPE, rs, rt, rd, sh, fn};
  endfunction

  function automatic logic [31:0] enc_i(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
                                        logic [15:0] imm);
    return {op, rs, rt, imm};
  endfunction

  function automatic logic [4:0] pick_reg();
    if ($urandom_range(0, 3) == 0) return 5'($urandom_range(0, 3));
    return 5'($urandom_range(0, 31));
  endfunction

  function automatic logic [15:0] pick_imm();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'h7FFF;
      2:       return 16'h8000;
      3:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] random_instruction();
    int unsigned pick;
    logic [31:0] word;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      word = $urandom;
    end else if (pick < 12) begin
      word = {mse_pkg::OP_RTYPE, 26'($urandom)};
    end else if (pick < 50) begin
      word = enc_r(R_FUNCTS[$urandom_range(0, 12)], pick_reg(), pick_reg(), pick_reg(),
                   5'($urandom));
    end else if (pick < 88) begin
      word = enc_i(I_OPS[$urandom_range(0, 5)], pick_reg(), pick_reg(), pick_imm());
    end else if (pick < 95) begin
      word = enc_i(PASS_OPS[$urandom_range(0, 3)], 5'($urandom), 5'($urandom),
                   16'($urandom));
    end else begin
      word = {6'($urandom), 26'($urandom)};
    end
    return word;
  endfunction

  task automatic idle_sender(input int unsigned n);
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= $urandom;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic send_instr(input logic [31:0] word);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    do @(posedge clk_i); while (!s_axis_tready);
    sent++;
    if (!calm && $urandom_range(0, 5) == 0) idle_sender($urandom_range(1, 10));
  endtask

  task automatic run_directed();
    send_instr(enc_i(mse_pkg::OP_LUI, 5'd0, 5'd1, 16'h8000));
    send_instr(enc_i(mse_pkg::OP_ADDIU, 5'd0, 5'd2, 16'hFFFF));
    send_instr(enc_i(mse_pkg::OP_LUI, 5'd0, 5'd3, 16'h7FFF));
    send_instr(enc_i(mse_pkg::OP_ORI, 5'd3, 5'd3, 16'hFFFF));
    send_instr(enc_i(mse_pkg::OP_ADDI, 5'd0, 5'd4, 16'h7FFF));
    send_instr(enc_r(mse_pkg::FN_ADD, 5'd3, 5'd4, 5'd5, 5'd0));
    send_instr(enc_r(mse_pkg::FN_ADDU, 5'd2, 5'd2, 5'd6, 5'd17));
    send_instr(enc_r(mse_pkg::FN_SUB, 5'd1, 5'd4, 5'd7, 5'd0));
    send_instr(enc_r(mse_pkg::FN_SUBU, 5'd0, 5'd2, 5'd8, 5'd0));
    send_instr(enc_r(mse_pkg::FN_AND, 5'd1, 5'd2, 5'd9, 5'd0));
    send_instr(enc_r(mse_pkg::FN_OR, 5'd1, 5'd3, 5'd10, 5'd0));
    send_instr(enc_r(mse_pkg::FN_XOR, 5'd2, 5'd3, 5'd11, 5'd0));
    send_instr(enc_r(mse_pkg::FN_NOR, 5'd0, 5'd0, 5'd12, 5'd0));
    send_instr(enc_r(mse_pkg::FN_SLT, 5'd1, 5'd3, 5'd13, 5'd0));
    send_instr(enc_r(mse_pkg::FN_SLTU, 5'd1, 5'd3, 5'd14, 5'd0));
    send_instr(enc_r(mse_pkg::FN_SLL, 5'd31, 5'd2, 5'd15, 5'd31));
    send_instr(enc_r(mse_pkg::FN_SRL, 5'd7, 5'd1, 5'd16, 5'd31));
    send_instr(enc_r(mse_pkg::FN_SRA, 5'd0, 5'd1, 5'd17, 5'd31));
    send_instr(enc_i(mse_pkg::OP_ANDI, 5'd2, 5'd18, 16'hFFFF));
    send_instr(enc_i(mse_pkg::OP_XORI, 5'd1, 5'd19, 16'h8000));
    send_instr(enc_i(mse_pkg::OP_ADDI, 5'd1, 5'd31, 16'h8000));
    send_instr(enc_r(mse_pkg::FN_ADD, 5'd2, 5'd2, 5'd0, 5'd0));
    send_instr(enc_i(mse_pkg::OP_LW, 5'd1, 5'd20, 16'h1234));
    send_instr(enc_i(mse_pkg::OP_SW, 5'd2, 5'd21, 16'hFFFF));
    send_instr(enc_i(mse_pkg::OP_BEQ, 5'd3, 5'd3, 16'h8000));
    send_instr(enc_i(mse_pkg::OP_BNE, 5'd4, 5'd5, 16'h0001));
    send_instr(enc_i(OP_UNDEFINED, 5'd1, 5'd22, 16'hFFFF));
    send_instr(enc_r(FN_UNDEFINED, 5'd1, 5'd2, 5'd23, 5'd0));
  endtask

  initial begin
    model         = new();
    sent          = 0;
    calm          = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    run_directed();
    for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == CALM_FROM) calm = 1'b1;
      send_instr(random_instruction());
    end
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (model.pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("%0d instruction words executed, %0d results checked: %0d register writes,",
             sent, model.checked, model.writes);
    $display("%0d rejected words, one long output stall and a back-to-back tail",
             model.rejected);
    if (model.errors == 0) begin
      $display("mips_subset_execute_core test passed");
    end else begin
      $display("mips_subset_execute_core test failed");
    end
    $finish;
  end

endmodule
